// ===== src/phs_pkg.sv =====
// Shared types, codes and constants of the plotter homing sequencer.
package phs_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_OK    = 2'd2;

    // Motor select codes.
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_TOOL = 2'd1;
    localparam logic [1:0] SEL_X    = 2'd2;
    localparam logic [1:0] SEL_Y    = 2'd3;

    // Motor command codes.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Capture point codes.
    localparam logic [2:0] CAP_NONE      = 3'd0;
    localparam logic [2:0] CAP_TOOL_UP   = 3'd1;
    localparam logic [2:0] CAP_X_MIN     = 3'd2;
    localparam logic [2:0] CAP_X_MAX     = 3'd3;
    localparam logic [2:0] CAP_Y_MIN     = 3'd4;
    localparam logic [2:0] CAP_Y_MAX     = 3'd5;
    localparam logic [2:0] CAP_TOOL_DOWN = 3'd6;

    // Run duties in percent.
    localparam logic signed [7:0] DUTY_ZERO      = 8'sd0;
    localparam logic signed [7:0] DUTY_TOOL_UP   = -8'sd30;
    localparam logic signed [7:0] DUTY_X_LEFT    = 8'sd50;
    localparam logic signed [7:0] DUTY_X_RIGHT   = -8'sd50;
    localparam logic signed [7:0] DUTY_Y_MIN     = -8'sd40;
    localparam logic signed [7:0] DUTY_Y_MAX     = 8'sd40;
    localparam logic signed [7:0] DUTY_TOOL_DOWN = 8'sd20;

    // Offsets added to a captured encoder position.
    localparam logic signed [31:0] OFS_TOOL_UP   = 32'sd20;
    localparam logic signed [31:0] OFS_X_MIN     = -32'sd30;
    localparam logic signed [31:0] OFS_X_MAX     = 32'sd30;
    localparam logic signed [31:0] OFS_Y_MIN     = 32'sd350;
    localparam logic signed [31:0] OFS_Y_MAX     = -32'sd30;
    localparam logic signed [31:0] OFS_TOOL_DOWN = -32'sd15;

    localparam logic [2:0] STEP_FIRST = 3'd1;

    typedef enum logic [12:0] {
        PH_IDLE         = 13'b0000000000001,
        PH_START        = 13'b0000000000010,
        PH_TOOL_UP      = 13'b0000000000100,
        PH_X_LEFT       = 13'b0000000001000,
        PH_X_RIGHT      = 13'b0000000010000,
        PH_Y_MIN        = 13'b0000000100000,
        PH_Y_MAX        = 13'b0000001000000,
        PH_GO_TOOL_DOWN = 13'b0000010000000,
        PH_TOOL_DOWN    = 13'b0000100000000,
        PH_SHOW         = 13'b0001000000000,
        PH_WAIT         = 13'b0010000000000,
        PH_STOPPED      = 13'b0100000000000,
        PH_FAILED       = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] step;
        logic       valid;
        logic [2:0] missing;
    } t_state;

    typedef struct packed {
        logic [1:0]         motor_select;
        logic [1:0]         motor_command;
        logic signed [7:0]  duty;
        logic [3:0]         phase;
        logic [2:0]         step_number;
        logic [2:0]         captured_which;
        logic signed [31:0] captured_value;
        logic               homing_done;
        logic               homing_failed;
        logic [2:0]         missing_mask;
        logic               last;
    } t_result;

    typedef struct packed {
        t_state     next;
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

    // Number reported for each one-hot phase.
    function automatic logic [3:0] phase_code(input t_phase ph);
        logic [3:0] code;
        case (ph)
            PH_IDLE:         code = 4'd0;
            PH_START:        code = 4'd1;
            PH_TOOL_UP:      code = 4'd2;
            PH_X_LEFT:       code = 4'd3;
            PH_X_RIGHT:      code = 4'd4;
            PH_Y_MIN:        code = 4'd5;
            PH_Y_MAX:        code = 4'd6;
            PH_GO_TOOL_DOWN: code = 4'd7;
            PH_TOOL_DOWN:    code = 4'd8;
            PH_SHOW:         code = 4'd9;
            PH_WAIT:         code = 4'd10;
            PH_STOPPED:      code = 4'd11;
            PH_FAILED:       code = 4'd12;
            default:         code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== src/phs_step.sv =====
// Next-state and result decoding for one input beat of the homing sequencer.
module phs_step (
    input  phs_pkg::t_state    i_state,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_connected_mask,
    input  logic               i_stalled,
    input  logic signed [31:0] i_motor_position,
    output phs_pkg::t_step_out o_step
);
    import phs_pkg::*;

    function automatic t_result mk_result(
        input logic [1:0]         sel,
        input logic [1:0]         cmd,
        input logic signed [7:0]  duty,
        input t_phase             ph,
        input logic [2:0]         step,
        input logic [2:0]         which,
        input logic signed [31:0] value,
        input logic               done,
        input logic               failed,
        input logic [2:0]         missing
    );
        t_result r;
        r.motor_select   = sel;
        r.motor_command  = cmd;
        r.duty           = duty;
        r.phase          = phase_code(ph);
        r.step_number    = step;
        r.captured_which = which;
        r.captured_value = value;
        r.homing_done    = done;
        r.homing_failed  = failed;
        r.missing_mask   = missing;
        r.last           = 1'b0;
        return r;
    endfunction

    logic                cap_en;
    logic                cap_go;
    t_phase              cap_next;
    logic [1:0]          cap_sel;
    logic [1:0]          cap_nsel;
    logic signed [7:0]   cap_nduty;
    logic [2:0]          cap_which;
    logic signed [31:0]  cap_ofs;
    logic signed [31:0]  cap_val;
    logic [2:0]          step_inc;
    logic [2:0]          new_missing;

    assign cap_val     = i_motor_position + cap_ofs;
    assign step_inc    = i_state.step + 3'd1;
    assign new_missing = ~i_connected_mask;

    always_comb begin
        cap_en    = 1'b0;
        cap_go    = 1'b0;
        cap_next  = i_state.phase;
        cap_sel   = SEL_NONE;
        cap_nsel  = SEL_NONE;
        cap_nduty = DUTY_ZERO;
        cap_which = CAP_NONE;
        cap_ofs   = 32'sd0;

        o_step.next  = i_state;
        o_step.count = 2'd0;
        o_step.res0  = mk_result(SEL_NONE, CMD_NONE, DUTY_ZERO, i_state.phase, i_state.step,
                                 CAP_NONE, 32'sd0, 1'b0, 1'b0, i_state.missing);
        o_step.res1  = o_step.res0;

        case (i_action)
            ACT_START: begin
                o_step.next.missing = new_missing;
                o_step.next.step    = STEP_FIRST;
                if (new_missing == 3'd0) begin
                    o_step.next.valid = 1'b1;
                    o_step.next.phase = PH_TOOL_UP;
                    o_step.count      = 2'd2;
                    o_step.res0 = mk_result(SEL_NONE, CMD_RESET, DUTY_ZERO, PH_START,
                                            STEP_FIRST, CAP_NONE, 32'sd0, 1'b0, 1'b0,
                                            new_missing);
                    o_step.res1 = mk_result(SEL_TOOL, CMD_RUN, DUTY_TOOL_UP, PH_TOOL_UP,
                                            STEP_FIRST, CAP_NONE, 32'sd0, 1'b0, 1'b0,
                                            new_missing);
                end else begin
                    o_step.next.valid = 1'b0;
                    o_step.next.phase = PH_WAIT;
                    o_step.count      = 2'd1;
                    o_step.res0 = mk_result(SEL_NONE, CMD_NONE, DUTY_ZERO, PH_WAIT,
                                            STEP_FIRST, CAP_NONE, 32'sd0, 1'b0, 1'b0,
                                            new_missing);
                end
            end
            ACT_TICK: begin
                case (i_state.phase)
                    PH_TOOL_UP: begin
                        cap_en = i_stalled; cap_go = 1'b1; cap_next = PH_X_LEFT;
                        cap_sel = SEL_TOOL; cap_nsel = SEL_X; cap_nduty = DUTY_X_LEFT;
                        cap_which = CAP_TOOL_UP; cap_ofs = OFS_TOOL_UP;
                    end
                    PH_X_LEFT: begin
                        cap_en = i_stalled; cap_go = 1'b1; cap_next = PH_X_RIGHT;
                        cap_sel = SEL_X; cap_nsel = SEL_X; cap_nduty = DUTY_X_RIGHT;
                        cap_which = CAP_X_MIN; cap_ofs = OFS_X_MIN;
                    end
                    PH_X_RIGHT: begin
                        cap_en = i_stalled; cap_go = 1'b1; cap_next = PH_Y_MIN;
                        cap_sel = SEL_X; cap_nsel = SEL_Y; cap_nduty = DUTY_Y_MIN;
                        cap_which = CAP_X_MAX; cap_ofs = OFS_X_MAX;
                    end
                    PH_Y_MIN: begin
                        cap_en = i_stalled; cap_go = 1'b1; cap_next = PH_Y_MAX;
                        cap_sel = SEL_Y; cap_nsel = SEL_Y; cap_nduty = DUTY_Y_MAX;
                        cap_which = CAP_Y_MIN; cap_ofs = OFS_Y_MIN;
                    end
                    PH_Y_MAX: begin
                        cap_en = i_stalled; cap_next = PH_GO_TOOL_DOWN;
                        cap_sel = SEL_Y; cap_which = CAP_Y_MAX; cap_ofs = OFS_Y_MAX;
                    end
                    PH_GO_TOOL_DOWN: begin
                        o_step.next.step  = step_inc;
                        o_step.next.phase = PH_TOOL_DOWN;
                        o_step.count      = 2'd1;
                        o_step.res0 = mk_result(SEL_TOOL, CMD_RUN, DUTY_TOOL_DOWN, PH_TOOL_DOWN,
                                                step_inc, CAP_NONE, 32'sd0, 1'b0, 1'b0,
                                                i_state.missing);
                    end
                    PH_TOOL_DOWN: begin
                        cap_en = i_stalled; cap_next = PH_SHOW;
                        cap_sel = SEL_TOOL; cap_which = CAP_TOOL_DOWN; cap_ofs = OFS_TOOL_DOWN;
                    end
                    PH_SHOW: begin
                        o_step.next.phase = PH_WAIT;
                        o_step.count      = 2'd1;
                        o_step.res0 = mk_result(SEL_NONE, CMD_NONE, DUTY_ZERO, PH_WAIT,
                                                i_state.step, CAP_NONE, 32'sd0, 1'b0, 1'b0,
                                                i_state.missing);
                    end
                    default: begin
                    end
                endcase
            end
            ACT_OK: begin
                if (i_state.phase != PH_IDLE && i_state.phase != PH_STOPPED &&
                    i_state.phase != PH_FAILED) begin
                    o_step.count      = 2'd1;
                    o_step.next.phase = i_state.valid ? PH_STOPPED : PH_FAILED;
                    o_step.res0 = mk_result(SEL_NONE, CMD_NONE, DUTY_ZERO, o_step.next.phase,
                                            i_state.step, CAP_NONE, 32'sd0, i_state.valid,
                                            !i_state.valid, i_state.missing);
                end
            end
            default: begin
            end
        endcase

        if (cap_en) begin
            o_step.next.phase = cap_next;
            if (cap_go) begin
                o_step.next.step = step_inc;
                o_step.count     = 2'd2;
                o_step.res0 = mk_result(cap_sel, CMD_STOP, DUTY_ZERO, i_state.phase,
                                        i_state.step, cap_which, cap_val, 1'b0, 1'b0,
                                        i_state.missing);
                o_step.res1 = mk_result(cap_nsel, CMD_RUN, cap_nduty, cap_next, step_inc,
                                        CAP_NONE, 32'sd0, 1'b0, 1'b0, i_state.missing);
            end else begin
                o_step.count = 2'd1;
                o_step.res0 = mk_result(cap_sel, CMD_STOP, DUTY_ZERO, cap_next,
                                        i_state.step, cap_which, cap_val, 1'b0, 1'b0,
                                        i_state.missing);
            end
        end

        if (o_step.count == 2'd1) begin
            o_step.res0.last = 1'b1;
        end
        if (o_step.count == 2'd2) begin
            o_step.res1.last = 1'b1;
        end
    end

endmodule

// ===== src/plotter_homing_sequencer_top.sv =====
// Top level of the plotter homing sequencer: state registers and two-entry result buffer.
//
// The sequencer walks a three-axis plotter through homing: tool up, x to its
// minimum, x to its maximum, y to its minimum, y to its maximum, then tool
// down. A start beat samples which motors are connected; with all three it
// emits a reset-all command followed by a run of the tool motor, otherwise it
// emits a single wait result and the run can only end as failed. Each tick
// beat looks at the stall flag of the motor being homed; a stall captures the
// position plus a fixed offset, stops that motor and, where the sequence goes
// on, starts the next one, so one input beat may give two result beats, the
// second flagged by o_last. An ok beat ends a run with a done or failed pulse.
// Timing: the state update and the results of a beat are worked out
// combinationally and land in a two-entry output buffer, so the first
// result is offered on the cycle after the input beat is taken. A beat that
// gives one result (or none) lets the next input beat follow in the very
// next cycle as long as the consumer keeps o_out_valid/i_out_ready flowing;
// a beat that gives two results holds the input side until the first of
// them has left, since the buffer only takes a new beat once it is empty or
// its last entry is leaving. The block needs no clearing time after reset.
module plotter_homing_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_connected_mask,
    input  logic               i_stalled,
    input  logic signed [31:0] i_motor_position,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_motor_select,
    output logic [1:0]         o_motor_command,
    output logic signed [7:0]  o_duty,
    output logic [3:0]         o_phase,
    output logic [2:0]         o_step_number,
    output logic [2:0]         o_captured_which,
    output logic signed [31:0] o_captured_value,
    output logic               o_homing_done,
    output logic               o_homing_failed,
    output logic [2:0]         o_missing_mask,
    output logic               o_last
);
    import phs_pkg::*;

    // Sequencer state, updated on every accepted input beat.
    t_state    r_state;
    t_step_out step_out;

    // Result buffer: r_res0 is the head, r_res1 only used behind it.
    t_result    r_res0, n_res0;
    t_result    r_res1, n_res1;
    logic [1:0] r_cnt,  n_cnt;

    logic in_fire;
    logic out_pop;

    phs_step u_step (
        .i_state          (r_state),
        .i_action         (i_action),
        .i_connected_mask (i_connected_mask),
        .i_stalled        (i_stalled),
        .i_motor_position (i_motor_position),
        .o_step           (step_out)
    );

    // Take a new beat when the buffer is empty, or when its single entry is
    // leaving in this same cycle.
    assign o_in_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_pop    = (r_cnt != 2'd0) && i_out_ready;

    always_comb begin
        n_res0 = r_res0;
        n_res1 = r_res1;
        n_cnt  = r_cnt;
        if (in_fire) begin
            n_res0 = step_out.res0;
            n_res1 = step_out.res1;
            n_cnt  = step_out.count;
        end else if (out_pop) begin
            n_res0 = r_res1;
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_IDLE;
            r_state.step    <= STEP_FIRST;
            r_state.valid   <= 1'b0;
            r_state.missing <= 3'd0;
            r_cnt           <= 2'd0;
        end else begin
            if (in_fire) begin
                r_state <= step_out.next;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign o_out_valid      = (r_cnt != 2'd0);
    assign o_motor_select   = r_res0.motor_select;
    assign o_motor_command  = r_res0.motor_command;
    assign o_duty           = r_res0.duty;
    assign o_phase          = r_res0.phase;
    assign o_step_number    = r_res0.step_number;
    assign o_captured_which = r_res0.captured_which;
    assign o_captured_value = r_res0.captured_value;
    assign o_homing_done    = r_res0.homing_done;
    assign o_homing_failed  = r_res0.homing_failed;
    assign o_missing_mask   = r_res0.missing_mask;
    assign o_last           = r_res0.last;

    // A start with every motor present offers the reset-all command first.
    a_start_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_action == ACT_START) && (i_connected_mask == 3'b111)
        |=> o_out_valid && (o_motor_command == CMD_RESET) && !o_last)
        else $error("start with all motors did not offer reset first");

    // When two results wait, the head one is never the last of its beat.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !r_res0.last && r_res1.last)
        else $error("result pair out of order");

    // A done or failed pulse always closes its beat and never shows together.
    a_end_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_homing_done || o_homing_failed)
        |-> o_last && !(o_homing_done && o_homing_failed))
        else $error("end pulse malformed");

    // A capture result is always a stop command.
    a_capture_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_captured_which != CAP_NONE) |-> (o_motor_command == CMD_STOP))
        else $error("capture without stop command");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the plotter homing sequencer, with its own prediction of every result.
`timescale 1ns / 100ps

module tb_top;
    import phs_pkg::*;

    // Phase numbers as the block reports them on o_phase.
    typedef enum logic [3:0] {
        PN_IDLE         = 4'd0,
        PN_START        = 4'd1,
        PN_TOOL_UP      = 4'd2,
        PN_X_LEFT       = 4'd3,
        PN_X_RIGHT      = 4'd4,
        PN_Y_MIN        = 4'd5,
        PN_Y_MAX        = 4'd6,
        PN_GO_TOOL_DOWN = 4'd7,
        PN_TOOL_DOWN    = 4'd8,
        PN_SHOW         = 4'd9,
        PN_WAIT         = 4'd10,
        PN_STOPPED      = 4'd11,
        PN_FAILED       = 4'd12
    } t_phase_num;

    // The fourth action code has no meaning; the block must ignore it.
    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam logic [2:0] ALL_MOTORS   = 3'b111;
    localparam int         HALF_PERIOD  = 4;
    localparam int         RESET_CYCLES = 8;
    localparam int         TARGET_BEATS = 1500;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 20;

    // Predicts the sequencer from the accepted input beats and keeps the
    // results still owed by the block, oldest first.
    class homing_scoreboard;
        t_phase_num  ph;
        logic [2:0]  step;
        bit          run_valid;
        logic [2:0]  missing;
        t_result     pending[$];
        int unsigned errors;

        function new();
            ph        = PN_IDLE;
            step      = STEP_FIRST;
            run_valid = 1'b0;
            missing   = 3'b000;
            errors    = 0;
        endfunction

        // Each result carries the phase, step and missing mask as they stand
        // at the moment it is produced.
        local function void emit(logic [1:0] sel, logic [1:0] cmd, logic signed [7:0] duty,
                                 logic [2:0] which, logic signed [31:0] value,
                                 logic done, logic failed);
            t_result r;
            r.motor_select   = sel;
            r.motor_command  = cmd;
            r.duty           = duty;
            r.phase          = ph;
            r.step_number    = step;
            r.captured_which = which;
            r.captured_value = value;
            r.homing_done    = done;
            r.homing_failed  = failed;
            r.missing_mask   = missing;
            r.last           = 1'b0;
            pending = {pending, r};
        endfunction

        // A stall stops the motor being homed and records its position plus
        // the offset. Where the sequence goes on, the stop still shows the old
        // phase and the next motor's run shows the new one; otherwise the stop
        // itself already carries the new phase.
        local function void capture(logic signed [31:0] pos, logic [2:0] which,
                                    logic signed [31:0] ofs, logic [1:0] sel, bit go_on,
                                    logic [1:0] next_sel, logic signed [7:0] next_duty,
                                    t_phase_num next_ph);
            logic signed [31:0] value;
            value = pos + ofs;
            if (!go_on) begin
                ph = next_ph;
                emit(sel, CMD_STOP, DUTY_ZERO, which, value, 1'b0, 1'b0);
            end else begin
                emit(sel, CMD_STOP, DUTY_ZERO, which, value, 1'b0, 1'b0);
                step = step + 3'd1;
                ph   = next_ph;
                emit(next_sel, CMD_RUN, next_duty, CAP_NONE, 32'sd0, 1'b0, 1'b0);
            end
        endfunction

        // Notes an accepted input beat and returns how many results it owes.
        function int note_beat(logic [1:0] action, logic [2:0] mask, logic stall,
                               logic signed [31:0] pos);
            int      owed;
            t_result r;
            owed = pending.size();
            case (action)
                ACT_START: begin
                    missing = ~mask;
                    step    = STEP_FIRST;
                    if (missing == 3'b000) begin
                        run_valid = 1'b1;
                        ph = PN_START;
                        emit(SEL_NONE, CMD_RESET, DUTY_ZERO, CAP_NONE, 32'sd0, 1'b0, 1'b0);
                        ph = PN_TOOL_UP;
                        emit(SEL_TOOL, CMD_RUN, DUTY_TOOL_UP, CAP_NONE, 32'sd0, 1'b0, 1'b0);
                    end else begin
                        run_valid = 1'b0;
                        ph = PN_WAIT;
                        emit(SEL_NONE, CMD_NONE, DUTY_ZERO, CAP_NONE, 32'sd0, 1'b0, 1'b0);
                    end
                end
                ACT_TICK: begin
                    case (ph)
                        PN_TOOL_UP: if (stall) capture(pos, CAP_TOOL_UP, OFS_TOOL_UP, SEL_TOOL,
                                                       1'b1, SEL_X, DUTY_X_LEFT, PN_X_LEFT);
                        PN_X_LEFT: if (stall) capture(pos, CAP_X_MIN, OFS_X_MIN, SEL_X,
                                                      1'b1, SEL_X, DUTY_X_RIGHT, PN_X_RIGHT);
                        PN_X_RIGHT: if (stall) capture(pos, CAP_X_MAX, OFS_X_MAX, SEL_X,
                                                       1'b1, SEL_Y, DUTY_Y_MIN, PN_Y_MIN);
                        PN_Y_MIN: if (stall) capture(pos, CAP_Y_MIN, OFS_Y_MIN, SEL_Y,
                                                     1'b1, SEL_Y, DUTY_Y_MAX, PN_Y_MAX);
                        PN_Y_MAX: if (stall) capture(pos, CAP_Y_MAX, OFS_Y_MAX, SEL_Y,
                                                     1'b0, SEL_NONE, DUTY_ZERO, PN_GO_TOOL_DOWN);
                        PN_GO_TOOL_DOWN: begin
                            // The tool goes down on the next tick whatever the stall flag says.
                            step = step + 3'd1;
                            ph   = PN_TOOL_DOWN;
                            emit(SEL_TOOL, CMD_RUN, DUTY_TOOL_DOWN, CAP_NONE, 32'sd0,
                                 1'b0, 1'b0);
                        end
                        PN_TOOL_DOWN: if (stall) capture(pos, CAP_TOOL_DOWN, OFS_TOOL_DOWN,
                                                         SEL_TOOL, 1'b0, SEL_NONE, DUTY_ZERO,
                                                         PN_SHOW);
                        PN_SHOW: begin
                            ph = PN_WAIT;
                            emit(SEL_NONE, CMD_NONE, DUTY_ZERO, CAP_NONE, 32'sd0, 1'b0, 1'b0);
                        end
                        default: ;
                    endcase
                end
                ACT_OK: begin
                    // Ok counts only between start and the waiting phase.
                    if (ph >= PN_START && ph <= PN_WAIT) begin
                        if (run_valid) begin
                            ph = PN_STOPPED;
                            emit(SEL_NONE, CMD_NONE, DUTY_ZERO, CAP_NONE, 32'sd0, 1'b1, 1'b0);
                        end else begin
                            ph = PN_FAILED;
                            emit(SEL_NONE, CMD_NONE, DUTY_ZERO, CAP_NONE, 32'sd0, 1'b0, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
            owed = pending.size() - owed;
            if (owed > 0) begin
                r = pending[pending.size() - 1];
                r.last = 1'b1;
                pending[pending.size() - 1] = r;
            end
            return owed;
        endfunction

        local function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: mismatch in %s, expected 'h%0h, got 'h%0h",
                         $time, name, want, got);
            end
        endfunction

        // Checks an accepted result beat against the oldest outstanding one.
        function void check_beat(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with none outstanding, phase %0d command %0d",
                         $time, got.phase, got.motor_command);
                return;
            end
            want = pending.pop_front();
            compare_field("motor_select", 32'(want.motor_select), 32'(got.motor_select));
            compare_field("motor_command", 32'(want.motor_command), 32'(got.motor_command));
            compare_field("duty", 32'(want.duty), 32'(got.duty));
            compare_field("phase", 32'(want.phase), 32'(got.phase));
            compare_field("step_number", 32'(want.step_number), 32'(got.step_number));
            compare_field("captured_which", 32'(want.captured_which),
                          32'(got.captured_which));
            compare_field("captured_value", want.captured_value, got.captured_value);
            compare_field("homing_done", 32'(want.homing_done), 32'(got.homing_done));
            compare_field("homing_failed", 32'(want.homing_failed), 32'(got.homing_failed));
            compare_field("missing_mask", 32'(want.missing_mask), 32'(got.missing_mask));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action = ACT_TICK;
    logic [2:0]         i_connected_mask = 3'b000;
    logic               i_stalled = 1'b0;
    logic signed [31:0] i_motor_position = 32'sd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_motor_select;
    logic [1:0]         o_motor_command;
    logic signed [7:0]  o_duty;
    logic [3:0]         o_phase;
    logic [2:0]         o_step_number;
    logic [2:0]         o_captured_which;
    logic signed [31:0] o_captured_value;
    logic               o_homing_done;
    logic               o_homing_failed;
    logic [2:0]         o_missing_mask;
    logic               o_last;

    homing_scoreboard sb;

    // Idling is set per phase of the run: the percentage of cycles in which
    // the sender holds back and in which the receiver refuses a result.
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned sent_beats = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_done = 1'b0;

    plotter_homing_sequencer_top DUT (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // Offers one input beat from the falling edge, after an optional random
    // gap, and keeps it steady until the block takes it at a rising edge.
    task automatic send_beat(input logic [1:0] action, input logic [2:0] mask,
                             input logic stall, input logic [31:0] pos);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_action         = action;
        i_connected_mask = mask;
        i_stalled        = stall;
        i_motor_position = pos;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        void'(sb.note_beat(action, mask, stall, pos));
        sent_beats++;
    endtask

    // Positions lean towards the edges of the 32-bit range so that the
    // offsets wrap now and then, in both directions.
    function automatic logic [31:0] random_position();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF - $urandom_range(400);
            1:       return 32'h8000_0000 + $urandom_range(400);
            2:       return $urandom_range(400) - 200;
            default: return $urandom;
        endcase
    endfunction

    // One homing run with random content: mostly a full, well-formed pass
    // through the axes, sometimes cut short by ok, restarted by a fresh
    // start or begun with motors missing. Stray beats fall in between.
    task automatic homing_run();
        int unsigned pick;
        logic [2:0]  mask;
        if ($urandom_range(3) == 0) begin
            pick = $urandom_range(2);
            send_beat((pick == 0) ? ACT_TICK : (pick == 1) ? ACT_OK : ACT_SPARE,
                      3'($urandom_range(7)), 1'($urandom_range(1)), random_position());
        end
        mask = ($urandom_range(9) < 8) ? ALL_MOTORS : 3'($urandom_range(7));
        send_beat(ACT_START, mask, 1'($urandom_range(1)), random_position());
        while (sb.ph != PN_STOPPED && sb.ph != PN_FAILED) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                mask = ($urandom_range(3) != 0) ? ALL_MOTORS : 3'($urandom_range(7));
                send_beat(ACT_START, mask, 1'($urandom_range(1)), random_position());
            end else if (pick < 4) begin
                send_beat(ACT_SPARE, 3'($urandom_range(7)), 1'($urandom_range(1)),
                          random_position());
            end else if (pick < 6 || (sb.ph == PN_WAIT && pick < 40)) begin
                send_beat(ACT_OK, 3'($urandom_range(7)), 1'($urandom_range(1)),
                          random_position());
            end else begin
                send_beat(ACT_TICK, 3'($urandom_range(7)), 1'($urandom_range(99) < 40),
                          random_position());
            end
        end
    endtask

    // Result side: beats are checked at the rising edge and ready changes at
    // the falling edge. Once asked, it refuses every result for a long
    // stretch so that the output buffer fills and the input side stalls.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_beat('{o_motor_select, o_motor_command, o_duty, o_phase,
                                o_step_number, o_captured_which, o_captured_value,
                                o_homing_done, o_homing_failed, o_missing_mask, o_last});
            end
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: stray beats while idle, one complete homing pass
        // with positions that make every offset wrap or cross zero, the
        // waiting and ended phases, a start with every motor missing, a
        // restart in the middle of a run and ok in the middle of homing.
        send_beat(ACT_TICK, 3'b000, 1'b0, 32'h0000_0000);
        send_beat(ACT_OK, 3'b111, 1'b1, 32'hFFFF_FFFF);
        send_beat(ACT_SPARE, 3'b111, 1'b1, 32'hFFFF_FFFF);
        send_beat(ACT_START, ALL_MOTORS, 1'b0, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b0, 32'h1234_5678);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h7FFF_FFF0);
        send_beat(ACT_TICK, 3'b010, 1'b1, 32'h8000_0000);
        send_beat(ACT_TICK, 3'b101, 1'b1, 32'hFFFF_FFF0);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h7FFF_FF00);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h5555_5555);
        send_beat(ACT_TICK, 3'b000, 1'b0, 32'hAAAA_AAAA);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h8000_0005);
        send_beat(ACT_TICK, 3'b000, 1'b0, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h0000_0000);
        send_beat(ACT_OK, 3'b000, 1'b0, 32'h0000_0000);
        send_beat(ACT_OK, 3'b000, 1'b0, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h0000_0000);
        send_beat(ACT_START, 3'b000, 1'b1, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h0000_0000);
        send_beat(ACT_OK, 3'b000, 1'b0, 32'h0000_0000);
        send_beat(ACT_START, ALL_MOTORS, 1'b0, 32'h0000_0000);
        send_beat(ACT_START, 3'b101, 1'b0, 32'h0000_0000);
        send_beat(ACT_START, ALL_MOTORS, 1'b0, 32'h0000_0000);
        send_beat(ACT_TICK, 3'b000, 1'b1, 32'h0000_0064);
        send_beat(ACT_OK, 3'b000, 1'b0, 32'h0000_0000);

        // Random part, in four quarters: free flow, a hesitant sender, a
        // hesitant receiver, then both. The long hold-off falls in the first
        // quarter, where the sender offers a beat on every cycle.
        while (sent_beats < TARGET_BEATS) begin
            case (sent_beats * 4 / TARGET_BEATS)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default: begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            if (sent_beats >= TARGET_BEATS / 8)
                hold_off_req = 1'b1;
            homing_run();
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS plotter_homing_sequencer_top");
        end else begin
            $display("FAIL plotter_homing_sequencer_top");
        end
        $finish;
    end

    // Watchdog: the run takes well under a tenth of this even at its slowest.
    initial begin
        #5_000_000;
        $display("FAIL plotter_homing_sequencer_top");
        $finish;
    end

endmodule

// ===== sim.f =====
src/phs_pkg.sv
src/phs_step.sv
src/plotter_homing_sequencer_top.sv
test/tb_top.sv
